// ===== hdl/ipc_pkg.sv =====
// ipc_pkg: shared constants, types and character helpers for the ip address text classifier
// used by ip_address_text_classifier and ipc_checker; no dependencies
package ipc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int CHAR_WIDTH = 8;
  localparam int COUNT_OUT_WIDTH = 32;
  localparam int OUT_DATA_WIDTH = 3 * COUNT_OUT_WIDTH;
  localparam int CLASS_WIDTH = 2;

  localparam logic [CHAR_WIDTH-1:0] CHAR_DOT = 8'h2E;
  localparam logic [CHAR_WIDTH-1:0] CHAR_COLON = 8'h3A;

  localparam logic [2:0] V4_SEGMENTS = 3'd4;
  localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
  localparam logic [11:0] V4_MAX_VALUE = 12'd255;
  localparam logic [3:0] V6_SEGMENTS = 4'd8;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;

  typedef enum logic [CLASS_WIDTH-1:0] {
    CLASS_IPV4    = 2'd0,
    CLASS_IPV6    = 2'd1,
    CLASS_INVALID = 2'd2
  } line_class_t;

  function automatic logic is_dec(input logic [CHAR_WIDTH-1:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [CHAR_WIDTH-1:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

endpackage

// ===== hdl/ip_address_text_classifier.sv =====
// ip_address_text_classifier: byte-stream ipv4 / ipv6 line classifier with saturating counters
// depends on ipc_pkg
//
//   channel | dir | tdata                              | tuser          | tlast
//   s_      | in  | [7:0] char_code                    | -              | end_of_line
//   m_      | out | [31:0] ipv4_count, [63:32] ipv6_   | [1:0] line_    | -
//           |     | count, [95:64] invalid_count       | class          |
//
// one byte per cycle; a byte passes the input register, the parsers update in the next cycle
// an end-of-line transaction passes the input register and then loads the result register
// the result register is the only output storage: while a result waits, bytes keep flowing,
// and only a further end-of-line waits in the input register
// rst (synchronous) clears both parsers, the counters and all valid flags
module ip_address_text_classifier #(
  parameter int COUNT_WIDTH = ipc_pkg::COUNT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ipc_pkg::CHAR_WIDTH-1:0]     s_tdata,   // char_code
  input  logic                               s_tlast,   // end_of_line
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ipc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,   // ipv4_count, ipv6_count, invalid_count
  output logic [ipc_pkg::CLASS_WIDTH-1:0]    m_tuser    // line_class
);

  localparam int CW = ipc_pkg::COUNT_OUT_WIDTH;
  localparam int EXT_WIDTH = (COUNT_WIDTH > CW) ? COUNT_WIDTH : CW;

  // input register
  logic                           in_valid;
  logic [ipc_pkg::CHAR_WIDTH-1:0] in_char;
  logic                           in_last;

  logic out_free;
  logic in_advance;
  logic fire;

  // parser state
  logic [2:0]  v4_segments, v4_segments_next;
  logic [2:0]  v4_seg_length, v4_seg_length_next;
  logic [7:0]  v4_seg_value, v4_seg_value_next;
  logic        v4_failed, v4_failed_next;
  logic [3:0]  v6_segments, v6_segments_next;
  logic [2:0]  v6_seg_length, v6_seg_length_next;
  logic        v6_failed, v6_failed_next;

  logic [11:0] v4_value_acc;
  logic [2:0]  v4_end_segments;
  logic [3:0]  v6_end_segments;
  logic        is_v4;
  logic        is_v6;

  ipc_pkg::line_class_t line_class, line_class_next;

  logic [COUNT_WIDTH-1:0] ipv4_total, ipv6_total, invalid_total;
  logic [EXT_WIDTH-1:0]   ipv4_ext, ipv6_ext, invalid_ext;

  assign out_free   = !m_tvalid || m_tready;
  assign in_advance = !in_last || out_free;
  assign fire       = in_valid && in_advance;
  assign s_tready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // per-byte parser update
  always_comb begin
    v4_segments_next   = v4_segments;
    v4_seg_length_next = v4_seg_length;
    v4_seg_value_next  = v4_seg_value;
    v4_failed_next     = v4_failed;
    v6_segments_next   = v6_segments;
    v6_seg_length_next = v6_seg_length;
    v6_failed_next     = v6_failed;
    v4_value_acc = {1'b0, v4_seg_value, 3'b000} + {3'b000, v4_seg_value, 1'b0}
                 + {8'd0, in_char[3:0]};

    if (!v4_failed) begin
      if (in_char == ipc_pkg::CHAR_DOT) begin
        if (v4_seg_length == 3'd0) begin
          v4_failed_next = 1'b1;
        end else begin
          v4_segments_next   = v4_segments + 3'd1;
          v4_failed_next     = (v4_segments == ipc_pkg::V4_SEGMENTS);
          v4_seg_length_next = 3'd0;
          v4_seg_value_next  = 8'd0;
        end
      end else if (!ipc_pkg::is_dec(in_char)) begin
        v4_failed_next = 1'b1;
      end else begin
        v4_seg_length_next = v4_seg_length + 3'd1;
        if (v4_seg_length == ipc_pkg::V4_MAX_DIGITS) begin
          v4_failed_next = 1'b1;
        end else begin
          v4_seg_value_next = v4_value_acc[7:0];
          v4_failed_next    = (v4_value_acc > ipc_pkg::V4_MAX_VALUE);
        end
      end
    end

    if (!v6_failed) begin
      if (in_char == ipc_pkg::CHAR_COLON) begin
        if (v6_seg_length == 3'd0) begin
          v6_failed_next = 1'b1;
        end else begin
          v6_segments_next   = v6_segments + 4'd1;
          v6_failed_next     = (v6_segments == ipc_pkg::V6_SEGMENTS);
          v6_seg_length_next = 3'd0;
        end
      end else if (!ipc_pkg::is_hex(in_char)) begin
        v6_failed_next = 1'b1;
      end else begin
        v6_seg_length_next = v6_seg_length + 3'd1;
        v6_failed_next     = (v6_seg_length == ipc_pkg::V6_MAX_DIGITS);
      end
    end
  end

  // end-of-line classification; an open segment counts as the last one
  always_comb begin
    v4_end_segments = v4_segments + {2'b00, (v4_seg_length != 3'd0)};
    v6_end_segments = v6_segments + {3'b000, (v6_seg_length != 3'd0)};
    is_v4 = !v4_failed && (v4_end_segments == ipc_pkg::V4_SEGMENTS);
    is_v6 = !v6_failed && (v6_end_segments == ipc_pkg::V6_SEGMENTS);
    if (is_v4) begin
      line_class_next = ipc_pkg::CLASS_IPV4;
    end else if (is_v6) begin
      line_class_next = ipc_pkg::CLASS_IPV6;
    end else begin
      line_class_next = ipc_pkg::CLASS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4_segments   <= '0;
      v4_seg_length <= '0;
      v4_seg_value  <= '0;
      v4_failed     <= 1'b0;
      v6_segments   <= '0;
      v6_seg_length <= '0;
      v6_failed     <= 1'b0;
    end else if (fire) begin
      if (in_last) begin
        v4_segments   <= '0;
        v4_seg_length <= '0;
        v4_seg_value  <= '0;
        v4_failed     <= 1'b0;
        v6_segments   <= '0;
        v6_seg_length <= '0;
        v6_failed     <= 1'b0;
      end else begin
        v4_segments   <= v4_segments_next;
        v4_seg_length <= v4_seg_length_next;
        v4_seg_value  <= v4_seg_value_next;
        v4_failed     <= v4_failed_next;
        v6_segments   <= v6_segments_next;
        v6_seg_length <= v6_seg_length_next;
        v6_failed     <= v6_failed_next;
      end
    end
  end

  // result register: class plus the saturating counters
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      ipv4_total    <= '0;
      ipv6_total    <= '0;
      invalid_total <= '0;
    end else if (fire && in_last) begin
      m_tvalid <= 1'b1;
      case (line_class_next)
        ipc_pkg::CLASS_IPV4: begin
          if (ipv4_total != '1) ipv4_total <= ipv4_total + 1'b1;
        end
        ipc_pkg::CLASS_IPV6: begin
          if (ipv6_total != '1) ipv6_total <= ipv6_total + 1'b1;
        end
        default: begin
          if (invalid_total != '1) invalid_total <= invalid_total + 1'b1;
        end
      endcase
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      line_class <= line_class_next;
    end
  end

  always_comb begin
    ipv4_ext    = '0;
    ipv6_ext    = '0;
    invalid_ext = '0;
    ipv4_ext[COUNT_WIDTH-1:0]    = ipv4_total;
    ipv6_ext[COUNT_WIDTH-1:0]    = ipv6_total;
    invalid_ext[COUNT_WIDTH-1:0] = invalid_total;
  end

  assign m_tdata = {invalid_ext[CW-1:0], ipv6_ext[CW-1:0], ipv4_ext[CW-1:0]};
  assign m_tuser = line_class;

endmodule

// ===== hdl/ipc_checker.sv =====
// ipc_checker: port-level assertions for ip_address_text_classifier, bound to the top level
// depends on ipc_pkg
module ipc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [ipc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input logic [ipc_pkg::CLASS_WIDTH-1:0]    m_tuser
);

  localparam int CW = ipc_pkg::COUNT_OUT_WIDTH;

  logic [ipc_pkg::OUT_DATA_WIDTH-1:0] m_tdata_prev;
  logic [2:0] cnt_changed;

  always_ff @(posedge clk) begin
    m_tdata_prev <= m_tdata;
  end

  assign cnt_changed = {m_tdata[3*CW-1:2*CW] != m_tdata_prev[3*CW-1:2*CW],
                        m_tdata[2*CW-1:CW]   != m_tdata_prev[2*CW-1:CW],
                        m_tdata[CW-1:0]      != m_tdata_prev[CW-1:0]};

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_class_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ipc_pkg::CLASS_IPV4) || (m_tuser == ipc_pkg::CLASS_IPV6) ||
                 (m_tuser == ipc_pkg::CLASS_INVALID))
    else $error("illegal line class");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && (m_tdata == '0))
    else $error("reset did not clear result and counters");

  a_one_counter: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(cnt_changed) <= 1)
    else $error("more than one counter moved in a cycle");

  a_change_means_result: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cnt_changed == 3'b000) || m_tvalid)
    else $error("counter moved without a result");

endmodule

bind ip_address_text_classifier ipc_checker u_ipc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
